[design/lsft_pkg.sv]
package lsft_pkg;

  localparam int PEAK_BITS   = 18;
  localparam int MAX_LOST    = 4;
  localparam int MAX_DISCARD = 128;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int DIV_W       = 32;
  localparam int DEN_W       = 8;
  localparam int DIV_CNT_W   = 5;

  localparam logic [1:0] DS_NONE    = 2'd0;
  localparam logic [1:0] DS_FOUND   = 2'd1;
  localparam logic [1:0] DS_NO_ROOM = 2'd2;
  localparam logic [1:0] DS_ERROR   = 2'd3;

  localparam logic [1:0] VD_NOSYNC = 2'd0;
  localparam logic [1:0] VD_SYNC   = 2'd1;
  localparam logic [1:0] VD_ERROR  = 2'd2;

  localparam logic [2:0] REG_SPR    = 3'd0;
  localparam logic [2:0] REG_SFLEN  = 3'd1;
  localparam logic [2:0] REG_SYM    = 3'd2;
  localparam logic [2:0] REG_FAVG   = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;
  localparam logic [2:0] REG_COEFF  = 3'd5;
  localparam logic [2:0] REG_WIN    = 3'd6;
  localparam logic [2:0] REG_CHK    = 3'd7;

  typedef struct packed {
    logic [2:0]  spr;
    logic [14:0] sflen;
    logic [11:0] sym;
    logic [3:0]  favg;
    logic [7:0]  period;
    logic [15:0] coeff;
    logic [11:0] win;
    logic        chk;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EVAL,
    OP_DIV_MOD,
    OP_DIV_Q1,
    OP_ACC,
    OP_DIV_Q2,
    OP_ACC2,
    OP_MUL1,
    OP_MUL2,
    OP_FIN,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic period_zero;
    logic frame_zero;
    logic div_done;
    logic out_busy;
  } st_t;

  function automatic logic [3:0] mod10(input logic [4:0] v);
    logic [4:0] t;
    if (v >= 5'd20) begin
      t = v - 5'd20;
    end else if (v >= 5'd10) begin
      t = v - 5'd10;
    end else begin
      t = v;
    end
    return t[3:0];
  endfunction

endpackage

[design/lsft_regs.sv]
module lsft_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsft_pkg::ADDR_W-1:0]  paddr,
  input  logic [lsft_pkg::DATA_W-1:0]  pwdata,
  output logic [lsft_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output lsft_pkg::cfg_t               cfg
);
  import lsft_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spr    <= 3'd1;
      cfg.sflen  <= 15'd1920;
      cfg.sym    <= 12'd128;
      cfg.favg   <= 4'd1;
      cfg.period <= 8'd0;
      cfg.coeff  <= 16'd6554;
      cfg.win    <= 12'd9;
      cfg.chk    <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_SPR:    cfg.spr    <= pwdata[2:0];
        REG_SFLEN:  cfg.sflen  <= pwdata[14:0];
        REG_SYM:    cfg.sym    <= pwdata[11:0];
        REG_FAVG:   cfg.favg   <= pwdata[3:0];
        REG_PERIOD: cfg.period <= pwdata[7:0];
        REG_COEFF:  cfg.coeff  <= pwdata[15:0];
        REG_WIN:    cfg.win    <= pwdata[11:0];
        REG_CHK:    cfg.chk    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPR:    prdata = {29'd0, cfg.spr};
      REG_SFLEN:  prdata = {17'd0, cfg.sflen};
      REG_SYM:    prdata = {20'd0, cfg.sym};
      REG_FAVG:   prdata = {28'd0, cfg.favg};
      REG_PERIOD: prdata = {24'd0, cfg.period};
      REG_COEFF:  prdata = {16'd0, cfg.coeff};
      REG_WIN:    prdata = {20'd0, cfg.win};
      REG_CHK:    prdata = {31'd0, cfg.chk};
      default:    prdata = '0;
    endcase
  end

endmodule

[design/lsft_div.sv]
module lsft_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lsft_pkg::DIV_W-1:0]  num,
  input  logic [lsft_pkg::DEN_W-1:0]  den,
  output logic [lsft_pkg::DIV_W-1:0]  quo,
  output logic [lsft_pkg::DEN_W-1:0]  rem,
  output logic                        done
);
  import lsft_pkg::*;

  logic [DIV_W-1:0]     n;
  logic [DEN_W-1:0]     r;
  logic [DEN_W-1:0]     d;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign trial = {r, n[DIV_W-1]};
  assign ge    = trial >= {1'b0, d};
  assign diff  = trial - {1'b0, d};
  assign quo   = n;
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      n    <= num;
      d    <= den;
      r    <= '0;
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      r   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      n   <= {n[DIV_W-2:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

[design/lsft_dp.sv]
module lsft_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lsft_pkg::cfg_t       cfg,
  input  lsft_pkg::cmd_t       cmd,
  output lsft_pkg::st_t        st,
  input  logic [1:0]           detect_status,
  input  logic [17:0]          peak_index,
  input  logic                 sss_seen,
  input  logic [3:0]           detected_subframe,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           sync_verdict,
  output logic                 tracking,
  output logic [3:0]           subframe_index,
  output logic [17:0]          realign_read,
  output logic [6:0]           discard_count,
  output logic signed [12:0]   sample_offset,
  output logic [17:0]          peak_position,
  output logic signed [31:0]   sfo_estimate
);
  import lsft_pkg::*;

  logic               track_mode;
  logic [3:0]         sf_cnt;
  logic [3:0]         found_count;
  logic [2:0]         lost_count;
  logic [15:0]        good_count;
  logic signed [31:0] acc;
  logic signed [31:0] sfo;
  logic [17:0]        exp_peak;
  logic signed [12:0] last_off;

  logic [1:0]         in_status;
  logic [17:0]        in_peak;
  logic               in_sss;
  logic [3:0]         in_det;

  logic [1:0]         verdict;
  logic [17:0]        realign;
  logic [6:0]         discard;
  logic               found;
  logic               frame_zero;
  logic signed [31:0] acc_new;
  logic signed [31:0] acc2;
  logic signed [49:0] prod1;
  logic signed [49:0] prod2;

  logic [3:0]         cnt_det;
  logic [3:0]         cnt_trk;
  logic               pilot;
  logic [3:0]         fc_inc;
  logic               peak_early;
  logic [18:0]        rf_sum;
  logic [17:0]        rf_clamp;
  logic [17:0]        room_prod;
  logic [2:0]         lost_inc;
  logic               lost_out;
  logic signed [19:0] off_raw;
  logic signed [12:0] off_sat;

  logic               div_start;
  logic [DIV_W-1:0]   div_num;
  logic [DIV_W-1:0]   div_q;
  logic [DEN_W-1:0]   div_rem;
  logic               div_done;
  logic [12:0]        off_mag;
  logic [31:0]        accn_mag;
  logic [31:0]        q_signed;
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_sat;

  logic signed [17:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] mul_p;

  logic signed [50:0] ema_sum;
  logic [50:0]        ema_mag;
  logic [50:0]        ema_t;
  logic signed [35:0] ema_val;
  logic signed [31:0] ema_sat;
  logic [31:0]        pend_t;
  logic [15:0]        pend_r;
  logic [6:0]         disc_val;
  logic signed [19:0] ep_sum;
  logic [17:0]        ep_clamp;

  assign cnt_det    = mod10({1'b0, in_det} + {2'b0, cfg.spr});
  assign cnt_trk    = mod10({1'b0, sf_cnt} + {2'b0, cfg.spr});
  assign pilot      = (cnt_trk == 4'd0) || (cnt_trk == 4'd5);
  assign fc_inc     = (found_count == 4'd15) ? found_count : found_count + 4'd1;
  assign peak_early = {1'b0, in_peak} < {6'b0, cfg.sym, 1'b0};
  assign rf_sum     = {1'b0, in_peak} + {5'b0, cfg.sflen[14:1]};
  assign rf_clamp   = rf_sum[18] ? {PEAK_BITS{1'b1}} : rf_sum[17:0];
  assign room_prod  = 18'(cfg.spr) * 18'(cfg.sflen);
  assign lost_inc   = (lost_count == 3'd7) ? lost_count : lost_count + 3'd1;
  assign lost_out   = lost_inc >= 3'(MAX_LOST);
  assign off_raw    = $signed({2'b0, in_peak}) - $signed({9'b0, cfg.win[11:1]})
                    - $signed({8'b0, cfg.sym});

  always_comb begin
    if (off_raw > 20'sd4095) begin
      off_sat = 13'sd4095;
    end else if (off_raw < -20'sd4096) begin
      off_sat = -13'sd4096;
    end else begin
      off_sat = off_raw[12:0];
    end
  end

  assign off_mag  = last_off[12] ? 13'(-last_off) : 13'(last_off);
  assign accn_mag = acc_new[31] ? (~acc_new + 32'd1) : acc_new;

  assign div_start = (cmd.op == OP_DIV_MOD) || (cmd.op == OP_DIV_Q1) ||
                     (cmd.op == OP_DIV_Q2);

  always_comb begin
    case (cmd.op)
      OP_DIV_MOD: div_num = {16'd0, good_count};
      OP_DIV_Q1:  div_num = {3'd0, off_mag, 16'd0} + {25'd0, cfg.period[7:1]};
      OP_DIV_Q2:  div_num = accn_mag + {25'd0, cfg.period[7:1]};
      default:    div_num = '0;
    endcase
  end

  lsft_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cfg.period),
    .quo   (div_q),
    .rem   (div_rem),
    .done  (div_done)
  );

  assign q_signed = last_off[12] ? (~div_q + 32'd1) : div_q;
  assign acc_sum  = {acc[31], acc} + {q_signed[31], q_signed};

  always_comb begin
    if (acc_sum > 33'sh0_7FFF_FFFF) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc_sum < -33'sh0_8000_0000) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  always_comb begin
    if (cmd.op == OP_MUL2) begin
      mul_a = $signed(18'h10000 - {2'b0, cfg.coeff});
      mul_b = sfo;
    end else begin
      mul_a = $signed({2'b0, cfg.coeff});
      mul_b = acc2;
    end
  end

  assign mul_p = mul_a * mul_b;

  assign ema_sum = {prod1[49], prod1} + {prod2[49], prod2};
  assign ema_mag = ema_sum[50] ? 51'(-ema_sum) : 51'(ema_sum);
  assign ema_t   = ema_mag + 51'd32768;
  assign ema_val = ema_sum[50] ? -$signed({1'b0, ema_t[50:16]})
                               : $signed({1'b0, ema_t[50:16]});

  always_comb begin
    if (ema_val > 36'sh0_7FFF_FFFF) begin
      ema_sat = 32'sh7FFF_FFFF;
    end else if (ema_val < -36'sh0_8000_0000) begin
      ema_sat = 32'sh8000_0000;
    end else begin
      ema_sat = ema_val[31:0];
    end
  end

  assign pend_t   = accn_mag + 32'd32768;
  assign pend_r   = pend_t[31:16];
  assign disc_val = (!acc_new[31] && pend_r != 16'd0 && pend_r < 16'(MAX_DISCARD))
                  ? pend_r[6:0] : 7'd0;
  assign ep_sum   = $signed({6'b0, cfg.sflen[14:1]}) + 20'(last_off);
  assign ep_clamp = ep_sum[19] ? 18'd0 : ep_sum[17:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      track_mode  <= 1'b0;
      sf_cnt      <= '0;
      found_count <= '0;
      lost_count  <= '0;
      good_count  <= '0;
      acc         <= '0;
      sfo         <= '0;
      exp_peak    <= '0;
      last_off    <= '0;
      found       <= 1'b0;
      frame_zero  <= 1'b1;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          in_status <= detect_status;
          in_peak   <= peak_index;
          in_sss    <= sss_seen;
          in_det    <= detected_subframe;
        end
        OP_EVAL: begin
          verdict    <= VD_NOSYNC;
          realign    <= '0;
          discard    <= '0;
          found      <= 1'b0;
          frame_zero <= 1'b1;
          if (!track_mode) begin
            case (in_status)
              DS_ERROR: verdict <= VD_ERROR;
              DS_FOUND: begin
                exp_peak <= in_peak;
                if (in_sss) sf_cnt <= cnt_det;
                if (fc_inc >= cfg.favg || peak_early) begin
                  realign     <= rf_clamp;
                  good_count  <= '0;
                  lost_count  <= '0;
                  found_count <= '0;
                  acc         <= '0;
                  track_mode  <= 1'b1;
                end else begin
                  found_count <= fc_inc;
                end
              end
              DS_NO_ROOM: realign <= {1'b0, room_prod[17:1]};
              default: ;
            endcase
          end else begin
            verdict <= VD_SYNC;
            sf_cnt  <= cnt_trk;
            if (pilot) begin
              case (in_status)
                DS_ERROR: verdict <= VD_ERROR;
                DS_NO_ROOM: begin
                  verdict    <= VD_NOSYNC;
                  track_mode <= 1'b0;
                end
                DS_NONE: begin
                  lost_count <= lost_inc;
                  if (lost_out) begin
                    track_mode <= 1'b0;
                    verdict    <= VD_NOSYNC;
                  end
                end
                default: begin
                  if (cnt_trk != in_det && cfg.chk && in_sss) begin
                    lost_count <= lost_inc;
                    if (lost_out) track_mode <= 1'b0;
                  end else begin
                    lost_count <= '0;
                  end
                  last_off <= off_sat;
                  found    <= 1'b1;
                end
              endcase
            end
          end
        end
        OP_DIV_Q1: frame_zero <= (div_rem == '0);
        OP_ACC: begin
          if (cfg.period == '0) begin
            acc_new <= {{3{last_off[12]}}, last_off, 16'd0};
            acc2    <= {{3{last_off[12]}}, last_off, 16'd0};
          end else begin
            acc_new <= acc_sat;
          end
        end
        OP_ACC2: acc2 <= acc_new[31] ? (~div_q + 32'd1) : div_q;
        OP_MUL1: prod1 <= mul_p;
        OP_MUL2: prod2 <= mul_p;
        OP_FIN: begin
          if (frame_zero) begin
            sfo     <= ema_sat;
            acc     <= '0;
            discard <= disc_val;
          end else begin
            acc <= acc_new;
          end
          exp_peak   <= ep_clamp;
          good_count <= good_count + 16'd1;
        end
        OP_OUT: begin
          sync_verdict   <= verdict;
          tracking       <= track_mode;
          subframe_index <= sf_cnt;
          realign_read   <= realign;
          discard_count  <= discard;
          sample_offset  <= last_off;
          peak_position  <= exp_peak;
          sfo_estimate   <= sfo;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign st.found       = found;
  assign st.period_zero = (cfg.period == '0);
  assign st.frame_zero  = frame_zero;
  assign st.div_done    = div_done;
  assign st.out_busy    = out_valid && !out_ready;

endmodule

[design/lsft_ctrl.sv]
module lsft_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lsft_pkg::st_t  st,
  output lsft_pkg::cmd_t cmd
);
  import lsft_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_CHECK, S_MODG, S_MODW, S_Q1G, S_Q1W, S_ACC,
    S_Q2G, S_Q2W, S_ACC2, S_MUL1, S_MUL2, S_FIN, S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_EVAL:  cmd.op = OP_EVAL;
      S_MODG:  cmd.op = OP_DIV_MOD;
      S_Q1G:   cmd.op = OP_DIV_Q1;
      S_ACC:   cmd.op = OP_ACC;
      S_Q2G:   cmd.op = OP_DIV_Q2;
      S_ACC2:  cmd.op = OP_ACC2;
      S_MUL1:  cmd.op = OP_MUL1;
      S_MUL2:  cmd.op = OP_MUL2;
      S_FIN:   cmd.op = OP_FIN;
      S_OUT:   cmd.op = st.out_busy ? OP_NONE : OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_EVAL;
        S_EVAL:  state <= S_CHECK;
        S_CHECK: begin
          if (!st.found) begin
            state <= S_OUT;
          end else if (st.period_zero) begin
            state <= S_ACC;
          end else begin
            state <= S_MODG;
          end
        end
        S_MODG:  state <= S_MODW;
        S_MODW:  if (st.div_done) state <= S_Q1G;
        S_Q1G:   state <= S_Q1W;
        S_Q1W:   if (st.div_done) state <= S_ACC;
        S_ACC: begin
          if (!st.frame_zero) begin
            state <= S_FIN;
          end else if (st.period_zero) begin
            state <= S_MUL1;
          end else begin
            state <= S_Q2G;
          end
        end
        S_Q2G:   state <= S_Q2W;
        S_Q2W:   if (st.div_done) state <= S_ACC2;
        S_ACC2:  state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_FIN;
        S_FIN:   state <= S_OUT;
        S_OUT:   if (!st.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/lte_subframe_sync_find_track_core.sv]
// Sequence: in find mode and on non-pilot subframes an input beat is loaded,
// evaluated and offered as a result; a tracking step with a zero period adds the
// accumulate, two multiply steps and the finish step, and one with a period adds up
// to three serial divides (subframe phase, offset share, average) as well.
// Throughput: the next input beat is taken as the result is offered, so a new beat
// waits until the last result is taken. Reset: synchronous rst returns to find mode,
// clears all counters and averages and loads the register defaults.
module lte_subframe_sync_find_track_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsft_pkg::ADDR_W-1:0]  paddr,
  input  logic [lsft_pkg::DATA_W-1:0]  pwdata,
  output logic [lsft_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   detect_status,
  input  logic [17:0]                  peak_index,
  input  logic                         sss_seen,
  input  logic [3:0]                   detected_subframe,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   sync_verdict,
  output logic                         tracking,
  output logic [3:0]                   subframe_index,
  output logic [17:0]                  realign_read,
  output logic [6:0]                   discard_count,
  output logic signed [12:0]           sample_offset,
  output logic [17:0]                  peak_position,
  output logic signed [31:0]           sfo_estimate
);
  import lsft_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  st_t  st;

  lsft_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lsft_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .st                (st),
    .detect_status     (detect_status),
    .peak_index        (peak_index),
    .sss_seen          (sss_seen),
    .detected_subframe (detected_subframe),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sync_verdict      (sync_verdict),
    .tracking          (tracking),
    .subframe_index    (subframe_index),
    .realign_read      (realign_read),
    .discard_count     (discard_count),
    .sample_offset     (sample_offset),
    .peak_position     (peak_position),
    .sfo_estimate      (sfo_estimate)
  );

endmodule
